// ===== src/pcpe_pkg.sv =====
package pcpe_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 16;

  // restoring steps of the modulo 2*pi reduction, one per cell
  localparam int RED_STEPS = 30 - FRAC_BITS;
  localparam int RED_IDX_W = $clog2(RED_STEPS);

  // cordic step index, sized for the arctangent table
  localparam int ATAN_IDX_W = 5;

  localparam int CFG_ADDR_W = 4;

  localparam logic [1:0] REG_CURVE_KIND = 2'd0;
  localparam logic [1:0] REG_RADIUS_X   = 2'd1;
  localparam logic [1:0] REG_RADIUS_Y   = 2'd2;
  localparam logic [1:0] REG_PITCH      = 2'd3;

  localparam logic [1:0] KIND_CIRCLE  = 2'd0;
  localparam logic [1:0] KIND_ELLIPSE = 2'd1;
  localparam logic [1:0] KIND_HELIX   = 2'd2;

  // 2*pi in Q3.60, rounded to F+30 fraction bits for the reduction
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] TP_FULL =
    (TWO_PI_Q60 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic [62:0] TP = TP_FULL[62:0];

  // multiple of 2*pi that makes every scaled angle non-negative
  localparam logic [62:0] RED_OFFSET    = TP << (29 - FRAC_BITS);
  localparam logic [32:0] RED_OFFSET_HI = RED_OFFSET[62:30];

  localparam logic [33:0] PI_Q30      = 34'd3373259426;
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
  localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
  localparam logic [33:0] WRAP_LIM    = TWO_PI_Q30 - HALF_PI_Q30;

  localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  localparam logic [23:0] XY_MAX    = 24'hFFFFFF;
  localparam logic [40:0] Z_POS_LIM = 41'h0FFFFFFFFFF;
  localparam logic [40:0] Z_NEG_LIM = 41'h10000000000;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef struct packed {
    logic signed [31:0] angle;
    logic [62:0]        rem;
  } red_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [33:0] z;
    logic               neg;
  } rot_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] radius_x;
    logic [23:0] radius_y;
    logic [23:0] pitch;
  } cfg_t;

endpackage

// ===== src/pcpe_if.sv =====
interface pcpe_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface pcpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] pos_x;
  logic signed [24:0] pos_y;
  logic signed [40:0] pos_z;
  logic signed [24:0] slope_x;
  logic signed [24:0] slope_y;
  logic signed [23:0] slope_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output slope_x, output slope_y, output slope_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input slope_x, input slope_y, input slope_z, output ready);
endinterface

// ===== src/parametric_curve_point_eval.sv =====
// channel   dir  handshake        payload
// in_ch     in   valid / ready    angle (signed q16.16 radians)
// out_ch    out  valid / ready    pos_x, pos_y, pos_z, slope_x, slope_y, slope_z
// apb       in   psel / penable   curve_kind, radius_x, radius_y, pitch
//
// one request per cycle sustained while the output channel is not stalled
// rst (synchronous, active high) empties every cell and loads the default registers
// each cell holds its request until the next one is free, so bubbles close up
// and a stalled output backs the chain up one cell at a time
module parametric_curve_point_eval import pcpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pcpe_in_if.sink               in_ch,
  pcpe_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration registers
  logic [1:0]  curve_kind;
  logic [23:0] radius_x;
  logic [23:0] radius_y;
  logic [23:0] pitch;
  cfg_t        cfg;

  // cell chain links
  logic red_v [RED_STEPS+1];
  logic red_r [RED_STEPS+1];
  red_t red_d [RED_STEPS+1];
  logic rot_v [CORDIC_STAGES+1];
  logic rot_r [CORDIC_STAGES+1];
  rot_t rot_d [CORDIC_STAGES+1];

  logic [32:0] entry_hi;

  assign pready = 1'b1;

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_kind <= KIND_CIRCLE;
      radius_x   <= 24'(1 << FRAC_BITS);
      radius_y   <= 24'(1 << FRAC_BITS);
      pitch      <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_CURVE_KIND: curve_kind <= pwdata[1:0];
        REG_RADIUS_X:   radius_x   <= pwdata[23:0];
        REG_RADIUS_Y:   radius_y   <= pwdata[23:0];
        REG_PITCH:      pitch      <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CURVE_KIND: prdata = {30'b0, curve_kind};
      REG_RADIUS_X:   prdata = {8'b0, radius_x};
      REG_RADIUS_Y:   prdata = {8'b0, radius_y};
      REG_PITCH:      prdata = {8'b0, pitch};
      default:        prdata = '0;
    endcase
  end

  assign cfg.kind     = curve_kind;
  assign cfg.radius_x = radius_x;
  assign cfg.radius_y = radius_y;
  assign cfg.pitch    = pitch;

  // angle << 30 plus a multiple of 2*pi, always non-negative;
  // the low 30 bits of the shifted angle are zero so only the top part adds
  assign entry_hi = {in_ch.angle[31], in_ch.angle} + RED_OFFSET_HI;

  always_comb begin
    red_d[0].angle = in_ch.angle;
    red_d[0].rem   = {entry_hi, RED_OFFSET[29:0]};
  end

  assign red_v[0]    = in_ch.valid;
  assign in_ch.ready = red_r[0];

  // modulo 2*pi by restoring subtraction, largest multiple first
  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    pcpe_reduce_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (RED_IDX_W'(RED_STEPS - 1 - k)),
      .up_valid (red_v[k]),
      .up_ready (red_r[k]),
      .up_data  (red_d[k]),
      .dn_valid (red_v[k+1]),
      .dn_ready (red_r[k+1]),
      .dn_data  (red_d[k+1])
    );
  end

  // round to q30 and fold into the cordic range
  pcpe_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .up_valid (red_v[RED_STEPS]),
    .up_ready (red_r[RED_STEPS]),
    .up_data  (red_d[RED_STEPS]),
    .dn_valid (rot_v[0]),
    .dn_ready (rot_r[0]),
    .dn_data  (rot_d[0])
  );

  // rotation mode cordic, one micro-rotation per cell
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    pcpe_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (ATAN_IDX_W'(k)),
      .up_valid (rot_v[k]),
      .up_ready (rot_r[k]),
      .up_data  (rot_d[k]),
      .dn_valid (rot_v[k+1]),
      .dn_ready (rot_r[k+1]),
      .dn_data  (rot_d[k+1])
    );
  end

  // radius scaling, helix z and the output register
  pcpe_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (rot_v[CORDIC_STAGES]),
    .up_ready (rot_r[CORDIC_STAGES]),
    .up_data  (rot_d[CORDIC_STAGES]),
    .out_ch   (out_ch)
  );

endmodule

// ===== src/pcpe_reduce_cell.sv =====
module pcpe_reduce_cell import pcpe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [RED_IDX_W-1:0] step,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  red_t                 up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output red_t                 dn_data
);

  logic [62:0] divisor;
  logic [63:0] diff;
  red_t        nxt;

  assign up_ready = !dn_valid || dn_ready;

  // one restoring step: take off 2*pi << step when it fits
  always_comb begin
    divisor   = TP << step;
    diff      = {1'b0, up_data.rem} - {1'b0, divisor};
    nxt.angle = up_data.angle;
    nxt.rem   = diff[63] ? up_data.rem : diff[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= nxt;
    end
  end

endmodule

// ===== src/pcpe_fold.sv =====
module pcpe_fold import pcpe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  red_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output rot_t dn_data
);

  logic [62:0]        rsum;
  logic [33:0]        z0;
  logic signed [34:0] zw;
  logic               neg;
  rot_t               nxt;

  assign up_ready = !dn_valid || dn_ready;

  // round to q30, then bring into [-pi/2, pi/2], folding by pi negates sin and cos
  always_comb begin
    rsum = up_data.rem + (63'd1 << (FRAC_BITS - 1));
    z0   = rsum[FRAC_BITS+33:FRAC_BITS];
    neg  = (z0 > HALF_PI_Q30) && (z0 < WRAP_LIM);
    if (neg) begin
      zw = $signed({1'b0, z0}) - $signed({1'b0, PI_Q30});
    end else if (z0 > PI_Q30) begin
      zw = $signed({1'b0, z0}) - $signed({1'b0, TWO_PI_Q30});
    end else begin
      zw = $signed({1'b0, z0});
    end
    nxt.angle = up_data.angle;
    nxt.x     = GAIN_Q30;
    nxt.y     = '0;
    nxt.z     = zw[33:0];
    nxt.neg   = neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= nxt;
    end
  end

endmodule

// ===== src/pcpe_cordic_cell.sv =====
module pcpe_cordic_cell import pcpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ATAN_IDX_W-1:0] step,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  rot_t                  up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output rot_t                  dn_data
);

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [33:0] at;
  rot_t               nxt;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    dx  = $signed(up_data.y) >>> step;
    dy  = $signed(up_data.x) >>> step;
    at  = $signed({4'b0, ATAN_Q30[step]});
    nxt = up_data;
    if (!up_data.z[33]) begin
      nxt.x = up_data.x - dx;
      nxt.y = up_data.y + dy;
      nxt.z = up_data.z - at;
    end else begin
      nxt.x = up_data.x + dx;
      nxt.y = up_data.y - dy;
      nxt.z = up_data.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= nxt;
    end
  end

endmodule

// ===== src/pcpe_scale.sv =====
module pcpe_scale import pcpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  rot_t              up_data,
  pcpe_out_if.source        out_ch
);

  localparam logic signed [58:0] ROUND_Q30 = 59'sd536870912;

  function automatic logic signed [24:0] coord(input logic signed [58:0] v);
    logic signed [28:0] sh;
    logic signed [28:0] lim;
    sh  = 29'(v >>> 30);
    lim = $signed({5'b0, XY_MAX});
    if (sh > lim) begin
      return 25'(lim);
    end else if (sh < -lim) begin
      return 25'(-lim);
    end
    return 25'(sh);
  endfunction

  // stage 1: radius products and helix products
  logic               s1_valid;
  logic               s1_ready;
  logic signed [57:0] s1_cx;
  logic signed [57:0] s1_sy;
  logic signed [57:0] s1_sx;
  logic signed [57:0] s1_cy;
  logic [55:0]        s1_m1;
  logic [53:0]        s1_sprod;
  logic               s1_helix;
  logic               s1_pneg;
  logic               s1_zneg;

  // stage 2: rounded coordinates, split z product
  logic               s2_valid;
  logic               s2_ready;
  logic signed [24:0] s2_px;
  logic signed [24:0] s2_py;
  logic signed [24:0] s2_sx;
  logic signed [24:0] s2_sy;
  logic [61:0]        s2_lo;
  logic [53:0]        s2_hi;
  logic [22:0]        s2_smag;
  logic               s2_helix;
  logic               s2_pneg;
  logic               s2_zneg;

  // stage 3: z product sum, slope z
  logic               s3_valid;
  logic               s3_ready;
  logic signed [24:0] s3_px;
  logic signed [24:0] s3_py;
  logic signed [24:0] s3_sx;
  logic signed [24:0] s3_sy;
  logic [54:0]        s3_q;
  logic signed [23:0] s3_sz;
  logic               s3_helix;
  logic               s3_zneg;

  // stage 4 is the output register
  logic               s4_valid;
  logic               s4_ready;

  logic signed [32:0] c;
  logic signed [32:0] s;
  logic [23:0]        rxe;
  logic [23:0]        rye;
  logic [23:0]        mp;
  logic [31:0]        ma;
  logic [54:0]        ssum;
  logic [55:0]        zmag;
  logic [55:0]        zsat;
  logic signed [40:0] pz;

  assign s4_ready = !s4_valid || out_ch.ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;

  always_comb begin
    c   = up_data.neg ? -up_data.x : up_data.x;
    s   = up_data.neg ? -up_data.y : up_data.y;
    rxe = (cfg.radius_x == '0) ? 24'd1 : cfg.radius_x;
    if (cfg.kind == KIND_ELLIPSE) begin
      rye = (cfg.radius_y == '0) ? 24'd1 : cfg.radius_y;
    end else begin
      rye = rxe;
    end
    mp = cfg.pitch[23] ? -cfg.pitch : cfg.pitch;
    ma = up_data.angle[31] ? 32'(-up_data.angle) : 32'(up_data.angle);
  end

  always_comb begin
    ssum = {1'b0, s1_sprod} + (55'd1 << 31);
  end

  always_comb begin
    zmag = 56'(s3_q >> FRAC_BITS) + 56'(s3_q[FRAC_BITS-1]);
    if (s3_zneg) begin
      zsat = (zmag > 56'(Z_NEG_LIM)) ? 56'(Z_NEG_LIM) : zmag;
      pz   = -$signed(zsat[40:0]);
    end else begin
      zsat = (zmag > 56'(Z_POS_LIM)) ? 56'(Z_POS_LIM) : zmag;
      pz   = $signed(zsat[40:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= up_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (s4_ready) begin
        s4_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && s1_ready) begin
      s1_cx    <= $signed({1'b0, rxe}) * c;
      s1_sy    <= $signed({1'b0, rye}) * s;
      s1_sx    <= $signed({1'b0, rxe}) * s;
      s1_cy    <= $signed({1'b0, rye}) * c;
      s1_m1    <= mp * ma;
      s1_sprod <= mp * INV_TWO_PI_Q32;
      s1_helix <= (cfg.kind == KIND_HELIX);
      s1_pneg  <= cfg.pitch[23];
      s1_zneg  <= cfg.pitch[23] ^ up_data.angle[31];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_px    <= coord($signed({s1_cx[57], s1_cx}) + ROUND_Q30);
      s2_py    <= coord($signed({s1_sy[57], s1_sy}) + ROUND_Q30);
      // slope x is minus rx sin, negated ahead of rounding
      s2_sx    <= coord(ROUND_Q30 - $signed({s1_sx[57], s1_sx}));
      s2_sy    <= coord($signed({s1_cy[57], s1_cy}) + ROUND_Q30);
      s2_lo    <= s1_m1[31:0] * INV_TWO_PI_Q32;
      s2_hi    <= s1_m1[55:32] * INV_TWO_PI_Q32;
      s2_smag  <= ssum[54:32];
      s2_helix <= s1_helix;
      s2_pneg  <= s1_pneg;
      s2_zneg  <= s1_zneg;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      s3_px    <= s2_px;
      s3_py    <= s2_py;
      s3_sx    <= s2_sx;
      s3_sy    <= s2_sy;
      s3_q     <= 55'(s2_hi) + 55'(s2_lo[61:32]);
      if (!s2_helix) begin
        s3_sz <= '0;
      end else if (s2_pneg) begin
        s3_sz <= -$signed({1'b0, s2_smag});
      end else begin
        s3_sz <= $signed({1'b0, s2_smag});
      end
      s3_helix <= s2_helix;
      s3_zneg  <= s2_zneg;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s4_ready) begin
      out_ch.pos_x   <= s3_px;
      out_ch.pos_y   <= s3_py;
      out_ch.slope_x <= s3_sx;
      out_ch.slope_y <= s3_sy;
      out_ch.slope_z <= s3_sz;
      out_ch.pos_z   <= s3_helix ? pz : '0;
    end
  end

  assign out_ch.valid = s4_valid;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import pcpe_pkg::*;

  // run shape
  localparam int N_DIR        = 25;
  localparam int N_PHASES     = 10;
  localparam int PHASE_LEN    = 50;
  localparam int MAX_REPORTS  = 10;
  localparam int PIPE_CYCLES  = RED_STEPS + CORDIC_STAGES + 5;
  localparam int TAIL_CYCLES  = PIPE_CYCLES + 20;
  // the limit sits well above the slowest run, even with both sides stalling
  localparam int LIMIT_CYCLES = 200000;

  // the spare kind code, evaluated like a circle
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // fixed-point constants of the curve arithmetic
  localparam longint unsigned TWO_PI_Q3_60 = 64'h6487ED5110B4611A;
  localparam longint TWO_PI_RED =
    longint'((TWO_PI_Q3_60 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  localparam longint PI30       = 64'sd3373259426;
  localparam longint HALF_PI30  = 64'sd1686629713;
  localparam longint TWO_PI30   = 64'sd6746518852;
  localparam longint GAIN30     = 64'sd652032874;
  localparam longint XY_LIM     = 64'sd16777215;
  localparam longint unsigned INV_TWO_PI32 = 64'd683565276;
  localparam longint unsigned Z_TOP        = 64'd1099511627775;

  localparam longint ATAN30 [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [24:0] pos_x;
    logic [24:0] pos_y;
    logic [40:0] pos_z;
    logic [24:0] slope_x;
    logic [24:0] slope_y;
    logic [23:0] slope_z;
  } point_t;

  // one directed request with the settings it runs under
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] rx;
    logic [23:0] ry;
    logic [23:0] pitch;
    logic [31:0] angle;
    logic        given;
    point_t      want;
  } dir_row_t;

  localparam point_t NO_POINT = '0;
  // radius of one lsb at t = 0: cos rounds to 1, sin to 0
  localparam point_t ONE_LSB_FLAT = '{25'd1, 25'd0, 41'd0, 25'd0, 25'd1, 24'd0};
  // same on a helix at the pitch extremes, slope_z = round(pitch / 2pi)
  localparam point_t ONE_LSB_RISE = '{25'd1, 25'd0, 41'd0, 25'd0, 25'd1, 24'd1335088};
  localparam point_t ONE_LSB_FALL = '{25'd1, 25'd0, 41'd0, 25'd0, 25'd1, -24'sd1335088};

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // settings after reset: unit circle
    '{KIND_CIRCLE, 24'h010000, 24'h010000, 24'h000000, 32'd0, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'h010000, 24'h010000, 24'h000000, 32'h7FFFFFFF, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'h010000, 24'h010000, 24'h000000, 32'h80000000, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'h010000, 24'h010000, 24'h000000, 32'd102944, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'h010000, 24'h010000, 24'h000000, -32'sd102944, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'h010000, 24'h010000, 24'h000000, 32'd205887, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'h010000, 24'h010000, 24'h000000, 32'd308831, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'h010000, 24'h010000, 24'h000000, 32'd411775, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'h010000, 24'h010000, 24'h000000, 32'd1, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'h010000, 24'h010000, 24'h000000, -32'sd1, 1'b0, NO_POINT},
    // zero radius acts as one lsb
    '{KIND_CIRCLE, 24'h000000, 24'h010000, 24'h000000, 32'd0, 1'b1, ONE_LSB_FLAT},
    // largest radius, near saturation of x and y
    '{KIND_CIRCLE, 24'hFFFFFF, 24'h010000, 24'h000000, 32'd0, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'hFFFFFF, 24'h010000, 24'h000000, 32'd102944, 1'b0, NO_POINT},
    '{KIND_CIRCLE, 24'hFFFFFF, 24'h010000, 24'h000000, -32'sd205887, 1'b0, NO_POINT},
    '{KIND_ELLIPSE, 24'h000000, 24'h000000, 24'h000000, 32'd0, 1'b1, ONE_LSB_FLAT},
    '{KIND_ELLIPSE, 24'h030000, 24'h008000, 24'h000000, 32'h00012345, 1'b0, NO_POINT},
    '{KIND_ELLIPSE, 24'hFFFFFF, 24'h000001, 24'h000000, 32'd205887, 1'b0, NO_POINT},
    // spare kind ignores radius_y like a circle
    '{KIND_SPARE, 24'h000000, 24'h123456, 24'h000000, 32'd0, 1'b1, ONE_LSB_FLAT},
    '{KIND_SPARE, 24'h020000, 24'h000001, 24'h000000, 32'd1000000, 1'b0, NO_POINT},
    // helix at the pitch extremes, then at a pitch of -1 lsb
    '{KIND_HELIX, 24'h000000, 24'h010000, 24'h7FFFFF, 32'd0, 1'b1, ONE_LSB_RISE},
    '{KIND_HELIX, 24'h000000, 24'h010000, 24'h800000, 32'd0, 1'b1, ONE_LSB_FALL},
    '{KIND_HELIX, 24'h010000, 24'h010000, 24'h7FFFFF, 32'h7FFFFFFF, 1'b0, NO_POINT},
    '{KIND_HELIX, 24'h010000, 24'h010000, 24'h800000, 32'h80000000, 1'b0, NO_POINT},
    '{KIND_HELIX, 24'h010000, 24'h010000, 24'h800000, 32'h7FFFFFFF, 1'b0, NO_POINT},
    '{KIND_HELIX, 24'hFFFFFF, 24'h010000, 24'hFFFFFF, -32'sd1, 1'b0, NO_POINT}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  pcpe_in_if  in_ch ();
  pcpe_out_if out_ch ();

  parametric_curve_point_eval uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the register file, updated on every write
  logic [1:0]         cfg_kind;
  logic [23:0]        cfg_rx;
  logic [23:0]        cfg_ry;
  logic signed [23:0] cfg_pitch;

  // points still owed by the block, oldest first
  point_t pending_pts [$];

  int sent_cnt;
  int checked_cnt;
  int err_cnt;
  int settings_cnt;
  int idle_pct;
  int stall_pct;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // round q30 product to q.16, clamp to the xy range
  function automatic longint fit_xy(input longint prod);
    longint v;
    v = (prod + (64'sd1 <<< 29)) >>> 30;
    if (v > XY_LIM) v = XY_LIM;
    if (v < -XY_LIM) v = -XY_LIM;
    return v;
  endfunction

  // cos and sin of t in q30: reduce modulo 2pi, fold into +-pi/2, rotate
  function automatic void unit_rotation(input longint t, output longint cs,
                                        output longint sn);
    longint scaled, turns, rem, z, x, y, dx, dy;
    logic   flip;
    int     i;
    scaled = t * 64'sd1073741824;
    turns  = scaled / TWO_PI_RED;
    rem    = scaled - turns * TWO_PI_RED;
    if (rem < 0) rem += TWO_PI_RED;
    z = (rem + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (z > PI30) z -= TWO_PI30;
    flip = 1'b0;
    if (z > HALF_PI30) begin
      z -= PI30;
      flip = 1'b1;
    end else if (z < -HALF_PI30) begin
      z += PI30;
      flip = 1'b1;
    end
    x = GAIN30;
    y = 0;
    for (i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN30[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN30[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = x;
    sn = y;
  endfunction

  // point and tangent of the configured curve at t
  function automatic point_t eval_curve(input logic signed [31:0] t_in);
    longint t, cs, sn, rx, ry, p, pz, sz;
    longint unsigned mp, ma, smag, m1, lo, q, zmag;
    point_t pt;
    t = t_in;
    unit_rotation(t, cs, sn);
    if (cfg_rx == 0) rx = 1;
    else rx = cfg_rx;
    if (cfg_kind != KIND_ELLIPSE) ry = rx;
    else if (cfg_ry == 0) ry = 1;
    else ry = cfg_ry;
    pz = 0;
    sz = 0;
    if (cfg_kind == KIND_HELIX) begin
      p    = cfg_pitch;
      mp   = (p < 0) ? -p : p;
      ma   = (t < 0) ? -t : t;
      smag = (mp * INV_TWO_PI32 + (64'd1 << 31)) >> 32;
      // |pitch * t| / 2pi split so that no partial product overflows
      m1   = mp * ma;
      lo   = (m1 & 64'hFFFF_FFFF) * INV_TWO_PI32;
      q    = (m1 >> 32) * INV_TWO_PI32 + (lo >> 32);
      zmag = (q >> FRAC_BITS) + ((q >> (FRAC_BITS - 1)) & 64'd1);
      sz   = (p < 0) ? -longint'(smag) : longint'(smag);
      if ((p < 0) != (t < 0)) begin
        if (zmag > Z_TOP + 1) zmag = Z_TOP + 1;
        pz = -longint'(zmag);
      end else begin
        if (zmag > Z_TOP) zmag = Z_TOP;
        pz = longint'(zmag);
      end
    end
    pt.pos_x   = 25'(fit_xy(rx * cs));
    pt.pos_y   = 25'(fit_xy(ry * sn));
    pt.pos_z   = 41'(pz);
    pt.slope_x = 25'(fit_xy(-(rx * sn)));
    pt.slope_y = 25'(fit_xy(ry * cs));
    pt.slope_z = 24'(sz);
    return pt;
  endfunction

  // angle mix: full range, a few turns, near quadrant edges, extremes
  function automatic logic [31:0] rand_angle();
    int q;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(3294198) - 1647099;
      6, 7: begin
        q = int'($urandom_range(40)) - 20;
        return q * 102944 + int'($urandom_range(16)) - 8;
      end
      default: begin
        q = $urandom_range(3);
        return (q == 0) ? 32'h7FFFFFFF : (q == 1) ? 32'h80000000 :
               (q == 2) ? 32'h00000000 : 32'hFFFFFFFF;
      end
    endcase
  endfunction

  function automatic logic [23:0] pick_radius();
    case ($urandom_range(7))
      0:       return 24'h000000;
      1:       return 24'h000001;
      2:       return 24'hFFFFFF;
      3:       return 24'($urandom_range(24'h040000, 1));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_pitch();
    case ($urandom_range(5))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  // apb write: setup cycle, then access until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CURVE_KIND: cfg_kind  = val[1:0];
      REG_RADIUS_X:   cfg_rx    = val[23:0];
      REG_RADIUS_Y:   cfg_ry    = val[23:0];
      REG_PITCH:      cfg_pitch = val[23:0];
      default: ;
    endcase
  endtask

  // all four registers; junk fills the unused upper bits
  task automatic apply_settings(input logic [1:0] kind, input logic [23:0] rx,
                                input logic [23:0] ry, input logic [23:0] pitch,
                                input logic [31:0] junk);
    write_reg(REG_CURVE_KIND, {junk[31:2], kind});
    write_reg(REG_RADIUS_X, {junk[31:24], rx});
    write_reg(REG_RADIUS_Y, {junk[31:24], ry});
    write_reg(REG_PITCH, {junk[31:24], pitch});
    settings_cnt++;
  endtask

  // stop sending and wait until every owed point has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 58; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 58; end
      default: begin idle_pct = 18; stall_pct = 18; end
    endcase
  endtask

  // one angle request; valid stays high across back-to-back requests
  task automatic send_angle(input logic [31:0] t, input logic use_given,
                            input point_t given);
    point_t want;
    want = use_given ? given : eval_curve(t);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.angle <= t;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pending_pts.push_back(want);
    sent_cnt++;
  endtask

  // result side: random stalls and the in-order check
  initial begin
    point_t got;
    point_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got = {out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
               out_ch.slope_x, out_ch.slope_y, out_ch.slope_z};
        if (pending_pts.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("error: point with no request pending: x=%0d y=%0d z=%0d",
                     $signed(got.pos_x), $signed(got.pos_y), $signed(got.pos_z));
        end else begin
          want = pending_pts.pop_front();
          checked_cnt++;
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $write("error: point %0d exp/got pos %0d/%0d %0d/%0d %0d/%0d",
                     checked_cnt,
                     $signed(want.pos_x), $signed(got.pos_x),
                     $signed(want.pos_y), $signed(got.pos_y),
                     $signed(want.pos_z), $signed(got.pos_z));
              $display(" slope %0d/%0d %0d/%0d %0d/%0d",
                       $signed(want.slope_x), $signed(got.slope_x),
                       $signed(want.slope_y), $signed(got.slope_y),
                       $signed(want.slope_z), $signed(got.slope_z));
            end
          end
        end
      end
      out_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
    end
  end

  // request side and run control
  initial begin
    dir_row_t row;
    logic [1:0] kind;
    int n;
    int ph;
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_ch.valid <= 1'b0;
    in_ch.angle <= '0;
    cfg_kind     = KIND_CIRCLE;
    cfg_rx       = 24'h010000;
    cfg_ry       = 24'h010000;
    cfg_pitch    = '0;
    sent_cnt     = 0;
    checked_cnt  = 0;
    err_cnt      = 0;
    settings_cnt = 0;
    set_idling(0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed rows; settings change only with the pipe empty
    for (n = 0; n < N_DIR; n++) begin
      row = DIR_ROWS[n];
      if ({row.kind, row.rx, row.ry, row.pitch} !=
          {cfg_kind, cfg_rx, cfg_ry, cfg_pitch}) begin
        settle();
        apply_settings(row.kind, row.rx, row.ry, row.pitch, 32'd0);
      end
      send_angle(row.angle, row.given, row.want);
    end

    // random phases, first four pinned to register extremes
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: apply_settings(KIND_CIRCLE, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, $urandom);
        1: apply_settings(KIND_ELLIPSE, 24'hFFFFFF, 24'h000001, 24'h800000, $urandom);
        2: apply_settings(KIND_HELIX, 24'hFFFFFF, 24'h000000, 24'h800000, $urandom);
        3: apply_settings(KIND_HELIX, 24'h010000, 24'hFFFFFF, 24'h7FFFFF, $urandom);
        default: begin
          kind = 2'($urandom_range(3));
          apply_settings(kind, pick_radius(), pick_radius(), pick_pitch(), $urandom);
        end
      endcase
      set_idling(ph % 4);
      repeat (PHASE_LEN) send_angle(rand_angle(), 1'b0, NO_POINT);
    end

    settle();
    // catch any stray point after the last one owed
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d angle requests (%0d directed), %0d points checked, %0d errors",
             sent_cnt, N_DIR, checked_cnt, err_cnt);
    $display("%0d register settings across circle, ellipse, helix and spare kind",
             settings_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("timeout: %0d points still pending", pending_pts.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pcpe_pkg.sv
src/pcpe_if.sv
src/pcpe_reduce_cell.sv
src/pcpe_fold.sv
src/pcpe_cordic_cell.sv
src/pcpe_scale.sv
src/parametric_curve_point_eval.sv
tb/sv/tb.sv
